// ===== sv/gsfe_pkg.sv =====
package gsfe_pkg;

  localparam int POS_W   = 16;
  localparam int AMP_W   = 16;
  localparam int SIGMA_W = 16;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int FIELD_W = 24;
  localparam int INV_W   = 32;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // log2(e), ln(2) and 1.0 in Q30
  localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
  localparam longint unsigned LN2_Q30   = 64'd744261118;
  localparam longint unsigned ONE_Q30   = 64'd1073741824;

  localparam logic signed [FIELD_W-1:0] FIELD_MAX = 24'sh7FFFFF;
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = 24'sh800000;

  // divider runs one quotient bit per step over a 33-bit numerator
  localparam logic [5:0] DIV_LAST = 6'd32;
  localparam logic [5:0] DIV_DONE = 6'd33;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [AMP_W-1:0] amp;
    logic [INV_W-1:0]        inv;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic div_init;
    logic div_step;
    logic tbl_write;
    logic issue;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic cnt_zero;
    logic issue_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/gaussian_sum_field_eval.sv =====
// Sum of up to MAX_GAUSSIANS Gaussian bumps evaluated at a query point.
// A load transaction (kind 0) writes one table slot and returns nothing; it
// occupies the block through the square, prepare, divide and write states, with
// the bit-serial divider forming 1/(2*sigma^2) one quotient bit per cycle over
// 33 steps. A query transaction (kind 1) sums n = min(active_count,
// MAX_GAUSSIANS) terms and skips the pipeline when n is zero: the entries
// are read one per cycle from the single table read port and stream through a
// 9-stage term pipeline (distance, scaling multiply, exp via 2^x table and
// shift, amplitude multiply, rounded accumulate) that drains before the
// saturated sum is registered. A result still waiting on the output holds the
// block until it is taken. One transaction is worked at a time; the next one
// is accepted the cycle after the result is registered, while it still waits
// on the output. Table slots read before ever being loaded return undefined terms.
module gaussian_sum_field_eval #(
  parameter int MAX_GAUSSIANS  = 16,
  parameter int EXP_TABLE_SIZE = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gsfe_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [gsfe_pkg::SLOT_W-1:0]         entry_index_i,
  input  logic signed [gsfe_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [gsfe_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [gsfe_pkg::AMP_W-1:0]   amplitude_i,
  input  logic [gsfe_pkg::SIGMA_W-1:0]        sigma_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [gsfe_pkg::FIELD_W-1:0] field_value_o,
  output logic                                saturated_o
);
  import gsfe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gsfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gsfe_dp #(
    .MAX_GAUSSIANS  (MAX_GAUSSIANS),
    .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (entry_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .amplitude_i   (amplitude_i),
    .sigma_i       (sigma_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .field_value_o (field_value_o),
    .saturated_o   (saturated_o)
  );

endmodule

// ===== sv/gsfe_ctrl.sv =====
module gsfe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          kind_i,
  input  gsfe_pkg::sts_t sts_i,
  output gsfe_pkg::cmd_t cmd_o
);
  import gsfe_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SQUARE = 8'b0000_0010,
    ST_PREP   = 8'b0000_0100,
    ST_DIVIDE = 8'b0000_1000,
    ST_WRITE  = 8'b0001_0000,
    ST_ISSUE  = 8'b0010_0000,
    ST_DRAIN  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          state_d = (kind_i == KIND_QUERY) ? ST_ISSUE : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.div_init = 1'b1;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.tbl_write = 1'b1;
        state_d = ST_IDLE;
      end
      ST_ISSUE: begin
        if (sts_i.cnt_zero) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
          if (sts_i.issue_last) state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/gsfe_dp.sv =====
module gsfe_dp #(
  parameter int MAX_GAUSSIANS  = 16,
  parameter int EXP_TABLE_SIZE = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gsfe_pkg::cmd_t                         cmd_i,
  output gsfe_pkg::sts_t                         sts_o,
  input  logic                                   cfg_valid_i,
  input  logic [gsfe_pkg::CNT_W-1:0]             cfg_data_i,
  input  logic [gsfe_pkg::SLOT_W-1:0]            entry_index_i,
  input  logic signed [gsfe_pkg::POS_W-1:0]      pos_x_i,
  input  logic signed [gsfe_pkg::POS_W-1:0]      pos_y_i,
  input  logic signed [gsfe_pkg::AMP_W-1:0]      amplitude_i,
  input  logic [gsfe_pkg::SIGMA_W-1:0]           sigma_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [gsfe_pkg::FIELD_W-1:0]    field_value_o,
  output logic                                   saturated_o
);
  import gsfe_pkg::*;

  localparam int AW      = (MAX_GAUSSIANS > 1) ? $clog2(MAX_GAUSSIANS) : 1;
  localparam int CW_RAW  = $clog2(MAX_GAUSSIANS + 1);
  localparam int CW      = (CW_RAW > CNT_W) ? CW_RAW : CNT_W;
  localparam int IW      = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int IXW     = $clog2(EXP_TABLE_SIZE);
  localparam int ACC_RAW = 18 + $clog2(MAX_GAUSSIANS);
  localparam int ACC_W   = (ACC_RAW > FIELD_W + 1) ? ACC_RAW : FIELD_W + 1;

  // 2^(-i/N) in Q16 via a truncated e^(-y) series in Q30, evaluated at elaboration
  function automatic logic [16:0] pow_entry(input int unsigned i);
    longint unsigned x, y, term, sum;
    x    = (longint'(i) << 30) / EXP_TABLE_SIZE;
    y    = (x * LN2_Q30) >> 30;
    term = ONE_Q30;
    sum  = ONE_Q30;
    term = ((term * y) >> 30) / 1;  sum = sum - term;
    term = ((term * y) >> 30) / 2;  sum = sum + term;
    term = ((term * y) >> 30) / 3;  sum = sum - term;
    term = ((term * y) >> 30) / 4;  sum = sum + term;
    term = ((term * y) >> 30) / 5;  sum = sum - term;
    term = ((term * y) >> 30) / 6;  sum = sum + term;
    term = ((term * y) >> 30) / 7;  sum = sum - term;
    term = ((term * y) >> 30) / 8;  sum = sum + term;
    term = ((term * y) >> 30) / 9;  sum = sum - term;
    term = ((term * y) >> 30) / 10; sum = sum + term;
    term = ((term * y) >> 30) / 11; sum = sum - term;
    term = ((term * y) >> 30) / 12; sum = sum + term;
    term = ((term * y) >> 30) / 13; sum = sum - term;
    term = ((term * y) >> 30) / 14; sum = sum + term;
    term = ((term * y) >> 30) / 15; sum = sum - term;
    return 17'((sum + 64'd8192) >> 14);
  endfunction

  logic [16:0] pow_rom [EXP_TABLE_SIZE];
  for (genvar g = 0; g < EXP_TABLE_SIZE; g++) begin : g_rom
    assign pow_rom[g] = pow_entry(g);
  end

  // ---------------- captured item and configuration
  logic [CNT_W-1:0]         active_q;
  logic [SLOT_W-1:0]        slot_q;
  logic signed [POS_W-1:0]  px_q, py_q;
  logic signed [AMP_W-1:0]  amp_q;
  logic [SIGMA_W-1:0]       sigma_q;
  logic [CW-1:0]            cnt_eff;
  logic [CW-1:0]            addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q  <= entry_index_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      amp_q   <= amplitude_i;
      sigma_q <= sigma_i;
    end
  end

  assign cnt_eff = (CW'(active_q) > CW'(MAX_GAUSSIANS)) ? CW'(MAX_GAUSSIANS) : CW'(active_q);

  // ---------------- inverse width: round(2^31 / sigma^2), restoring divider
  logic [31:0] s2_q, quo_q, rem_q;
  logic [32:0] num_q, rem_sh, rem_sub;
  logic [5:0]  div_cnt_q;

  assign rem_sh  = {rem_q, num_q[32]};
  assign rem_sub = rem_sh - {1'b0, s2_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      s2_q <= sigma_q * sigma_q;
    end
    if (cmd_i.div_init) begin
      num_q <= 33'h0_8000_0000 + {2'b0, s2_q[31:1]};
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[31:0], 1'b0};
      if (rem_sh >= {1'b0, s2_q}) begin
        rem_q <= rem_sub[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + 6'd1;
    end
  end

  // ---------------- entry table
  entry_t          mem_q [MAX_GAUSSIANS];
  entry_t          rd_q;
  entry_t          wr_entry;
  logic [IW-1:0]   widx;
  logic            we;

  assign widx = IW'(slot_q);
  assign we   = cmd_i.tbl_write && (32'(slot_q) < 32'(MAX_GAUSSIANS));

  always_comb begin
    wr_entry.x   = px_q;
    wr_entry.y   = py_q;
    wr_entry.amp = (sigma_q == '0) ? '0 : amp_q;
    wr_entry.inv = (sigma_q == '0) ? '0 : quo_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[widx[AW-1:0]] <= wr_entry;
    if (cmd_i.issue) rd_q <= mem_q[addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.capture) begin
      addr_q <= '0;
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + CW'(1);
    end
  end

  // ---------------- term pipeline, stages 1..9
  logic [9:1] v_q;

  logic signed [16:0] dx, dy;
  logic signed [33:0] dxsq, dysq;
  logic [32:0]        s1_dx2_q, s1_dy2_q;
  logic [33:0]        s2_d2_q;
  logic [49:0]        s3_plo_q, s3_phi_q;
  logic [65:0]        t_full;
  logic [19:0]        s4_t16_q;
  logic [50:0]        uprod;
  logic [20:0]        s5_u_q;
  logic [26:0]        fprod;
  logic [4:0]         s6_k_q;
  logic [IXW-1:0]     s6_idx_q;
  logic [16:0]        s7_e_q;
  logic signed [33:0] s8_p_q;
  logic [33:0]        mag;
  logic [17:0]        rnd;
  logic [INV_W-1:0]   s1_inv_q, s2_inv_q;
  logic signed [AMP_W-1:0] s1_amp_q, s2_amp_q, s3_amp_q, s4_amp_q;
  logic signed [AMP_W-1:0] s5_amp_q, s6_amp_q, s7_amp_q;
  logic               s4_zero_q, s5_zero_q, s6_zero_q;
  logic signed [ACC_W-1:0] acc_q, term_ext;

  assign dx   = {px_q[15], px_q} - {rd_q.x[15], rd_q.x};
  assign dy   = {py_q[15], py_q} - {rd_q.y[15], rd_q.y};
  assign dxsq = dx * dx;
  assign dysq = dy * dy;

  assign t_full = {16'b0, s3_plo_q} + {s3_phi_q, 16'b0};

  assign uprod = {31'b0, s4_t16_q} * {20'b0, LOG2E_Q30[30:0]};
  assign fprod = {11'b0, s5_u_q[15:0]} * 27'(EXP_TABLE_SIZE);
  assign mag   = s8_p_q[33] ? 34'(-s8_p_q) : 34'(s8_p_q);
  assign rnd   = 18'((mag + 34'd32768) >> 16);
  assign term_ext = s8_p_q[33] ? -ACC_W'($signed({1'b0, rnd}))
                               :  ACC_W'($signed({1'b0, rnd}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[8:1], cmd_i.issue};
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_q[1]) begin
      s1_dx2_q <= dxsq[32:0];
      s1_dy2_q <= dysq[32:0];
      s1_inv_q <= rd_q.inv;
      s1_amp_q <= rd_q.amp;
    end
    if (v_q[2]) begin
      s2_d2_q  <= {1'b0, s1_dx2_q} + {1'b0, s1_dy2_q};
      s2_inv_q <= s1_inv_q;
      s2_amp_q <= s1_amp_q;
    end
    if (v_q[3]) begin
      s3_plo_q <= s2_d2_q * s2_inv_q[15:0];
      s3_phi_q <= s2_d2_q * s2_inv_q[31:16];
      s3_amp_q <= s2_amp_q;
    end
    if (v_q[4]) begin
      // t >= 16.0 (Q.32) flushes the term
      s4_zero_q <= |t_full[65:36];
      s4_t16_q  <= t_full[35:16];
      s4_amp_q  <= s3_amp_q;
    end
    if (v_q[5]) begin
      s5_u_q    <= uprod[50:30];
      s5_zero_q <= s4_zero_q;
      s5_amp_q  <= s4_amp_q;
    end
    if (v_q[6]) begin
      s6_k_q    <= s5_u_q[20:16];
      s6_idx_q  <= fprod[16 +: IXW];
      s6_zero_q <= s5_zero_q;
      s6_amp_q  <= s5_amp_q;
    end
    if (v_q[7]) begin
      s7_e_q   <= s6_zero_q ? '0 : (pow_rom[s6_idx_q] >> s6_k_q);
      s7_amp_q <= s6_amp_q;
    end
    if (v_q[8]) begin
      s8_p_q <= s7_amp_q * $signed({1'b0, s7_e_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.capture) begin
      acc_q <= '0;
    end else if (v_q[9]) begin
      acc_q <= acc_q + term_ext;
    end
  end

  // ---------------- output register
  logic                      out_valid_q;
  logic signed [FIELD_W-1:0] field_q;
  logic                      sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      if (acc_q > ACC_W'(FIELD_MAX)) begin
        field_q <= FIELD_MAX;
        sat_q   <= 1'b1;
      end else if (acc_q < ACC_W'(FIELD_MIN)) begin
        field_q <= FIELD_MIN;
        sat_q   <= 1'b1;
      end else begin
        field_q <= acc_q[FIELD_W-1:0];
        sat_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_value_o = field_q;
  assign saturated_o   = sat_q;

  assign sts_o.div_last   = (div_cnt_q == DIV_LAST);
  assign sts_o.cnt_zero   = (cnt_eff == '0);
  assign sts_o.issue_last = ((addr_q + CW'(1)) == cnt_eff);
  assign sts_o.pipe_busy  = |v_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

`ifndef NO_ASSERTIONS
  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (addr_q < cnt_eff))
    else $error("entry read beyond active count");

  a_write_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tbl_write |-> (div_cnt_q == DIV_DONE))
    else $error("table written before divider finished");

  a_result_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result_load |-> (!(|v_q) && (!out_valid_q || out_ready_i)))
    else $error("result taken with terms in flight or output busy");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result_load |=> out_valid_q)
    else $error("loaded result not presented");
`endif

endmodule

// ===== tb/sv/gsfe_checker.sv =====
module gsfe_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [gsfe_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic                                kind_i,
  input  logic [gsfe_pkg::SLOT_W-1:0]         entry_index_i,
  input  logic signed [gsfe_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [gsfe_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [gsfe_pkg::AMP_W-1:0]   amplitude_i,
  input  logic [gsfe_pkg::SIGMA_W-1:0]        sigma_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [gsfe_pkg::FIELD_W-1:0] field_value_i,
  input  logic                                saturated_i,
  output int                                  error_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsfe_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int POW_SIZE  = 64;

  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    logic                      sat;
  } field_result_t;

  logic signed [POS_W-1:0] ctr_x [NUM_SLOTS];
  logic signed [POS_W-1:0] ctr_y [NUM_SLOTS];
  logic signed [AMP_W-1:0] amp_tab [NUM_SLOTS];
  logic [INV_W-1:0]        inv_tab [NUM_SLOTS];
  logic [CNT_W-1:0]        sum_count;
  longint unsigned         pow2_frac [POW_SIZE];
  field_result_t           field_q [$];

  assign pending_o = field_q.size();

  initial begin
    longint unsigned x, y, term, acc;
    for (int i = 0; i < POW_SIZE; i++) begin
      x = (longint'(i) << 30) / POW_SIZE;
      y = (x * LN2_Q30) >> 30;
      term = ONE_Q30;
      acc = ONE_Q30;
      for (int n = 1; n < 16; n++) begin
        term = ((term * y) >> 30) / n;
        if (n % 2) acc = acc - term;
        else acc = acc + term;
      end
      pow2_frac[i] = (acc + (1 << 13)) >> 14;
    end
  end

  function automatic longint unsigned decay_q16(longint unsigned d2, longint unsigned inv);
    longint unsigned t, u, k, f, idx;
    if (inv != 0 && d2 > 64'hFFFF_FFFF_FFFF_FFFF / inv) return 0;
    t = d2 * inv;
    if (t >= (64'd16 << 32)) return 0;
    u = ((t >> 16) * LOG2E_Q30) >> 30;
    k = u >> 16;
    f = u & 64'hFFFF;
    idx = (f * POW_SIZE) >> 16;
    if (idx >= POW_SIZE) idx = POW_SIZE - 1;
    if (k > 31) return 0;
    return pow2_frac[idx] >> k;
  endfunction

  function automatic field_result_t field_at(logic signed [POS_W-1:0] qx,
                                             logic signed [POS_W-1:0] qy);
    longint        total, dx, dy, p, r;
    longint unsigned d2, mag;
    int            n;
    field_result_t res;
    total = 0;
    n = (sum_count > NUM_SLOTS) ? NUM_SLOTS : int'(sum_count);
    for (int i = 0; i < n; i++) begin
      dx = longint'(qx) - longint'(ctr_x[i]);
      dy = longint'(qy) - longint'(ctr_y[i]);
      d2 = dx * dx + dy * dy;
      p = longint'(amp_tab[i]) * longint'(decay_q16(d2, inv_tab[i]));
      mag = (p < 0) ? -p : p;
      r = (mag + 32768) >> 16;
      total += (p < 0) ? -r : r;
    end
    res.sat = 1'b0;
    if (total > longint'(FIELD_MAX)) begin
      total = FIELD_MAX;
      res.sat = 1'b1;
    end else if (total < longint'(FIELD_MIN)) begin
      total = FIELD_MIN;
      res.sat = 1'b1;
    end
    res.value = total[FIELD_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint unsigned s2;
    field_result_t exp_res;
    if (!rst_ni) begin
      sum_count <= '0;
      error_count_o <= 0;
      field_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) sum_count <= cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_LOAD) begin
          ctr_x[entry_index_i] = pos_x_i;
          ctr_y[entry_index_i] = pos_y_i;
          if (sigma_i == 0) begin
            amp_tab[entry_index_i] = '0;
            inv_tab[entry_index_i] = '0;
          end else begin
            s2 = longint'(sigma_i) * longint'(sigma_i);
            amp_tab[entry_index_i] = amplitude_i;
            inv_tab[entry_index_i] = ((64'd1 << 31) + (s2 >> 1)) / s2;
          end
        end else begin
          field_q = {field_q, field_at(pos_x_i, pos_y_i)};
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (field_q.size() == 0) begin
          $display("%0t: unexpected result field_value=%0d saturated=%0b",
                   $time, field_value_i, saturated_i);
          error_count_o <= error_count_o + 1;
        end else begin
          exp_res = field_q.pop_front();
          if (field_value_i !== exp_res.value || saturated_i !== exp_res.sat) begin
            $display("%0t: mismatch expected field_value=%0d saturated=%0b, actual %0d %0b",
                     $time, exp_res.value, exp_res.sat, field_value_i, saturated_i);
            error_count_o <= error_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_gaussian_sum_field_eval.sv =====
module tb_gaussian_sum_field_eval;
  timeunit 1ns;
  timeprecision 1ps;
  import gsfe_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic kind_i = KIND_LOAD;
  logic [SLOT_W-1:0] entry_index_i = '0;
  logic signed [POS_W-1:0] pos_x_i = '0;
  logic signed [POS_W-1:0] pos_y_i = '0;
  logic signed [AMP_W-1:0] amplitude_i = '0;
  logic [SIGMA_W-1:0] sigma_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [FIELD_W-1:0] field_value_o;
  logic saturated_o;
  int error_count, pending;
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  always #1 clk_i = ~clk_i;

  gaussian_sum_field_eval dut (.*);

  gsfe_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_data_i, .in_valid_i, .in_ready_i(in_ready_o),
    .kind_i, .entry_index_i, .pos_x_i, .pos_y_i, .amplitude_i, .sigma_i,
    .out_valid_i(out_valid_o), .out_ready_i, .field_value_i(field_value_o),
    .saturated_i(saturated_o), .error_count_o(error_count), .pending_o(pending)
  );

  // receiver stalls in bursts
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 14);
        out_ready_i <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_item(logic k, logic [SLOT_W-1:0] idx, logic [POS_W-1:0] x,
                           logic [POS_W-1:0] y, logic [AMP_W-1:0] a,
                           logic [SIGMA_W-1:0] s);
    int gap;
    bit rdy;
    // valid drops between transactions, sometimes for a random gap
    @(posedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    entry_index_i <= idx;
    pos_x_i <= x;
    pos_y_i <= y;
    amplitude_i <= a;
    sigma_i <= s;
    // ready is sampled mid-cycle so the accepting edge is the one that counts
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    in_valid_i <= 1'b0;
  endtask

  task automatic set_count(logic [CNT_W-1:0] c);
    repeat (60) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small sigma near centers so terms are nonzero
  task automatic rand_load(int slot);
    logic [SIGMA_W-1:0] s;
    logic [POS_W-1:0] x, y;
    case ($urandom_range(0, 5))
      0: s = 16'($urandom);
      1: s = 16'h0;
      default: s = 16'($urandom_range(64, 2048));
    endcase
    x = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
    y = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
    send_item(KIND_LOAD, 4'(slot), x, y, 16'($urandom), s);
  endtask

  task automatic rand_query();
    logic [POS_W-1:0] x, y;
    x = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
    y = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
    send_item(KIND_QUERY, '0, x, y, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // no entries summed: query returns zero
    send_item(KIND_QUERY, 4'hF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    // fill every slot: max amplitude, tight width, all at origin
    for (int i = 0; i < 16; i++)
      send_item(KIND_LOAD, 4'(i), 16'h0, 16'h0, 16'h7FFF, 16'h0100);
    set_count(5'd31);
    send_item(KIND_QUERY, '0, 16'h0, 16'h0, '0, '0);
    send_item(KIND_QUERY, '0, 16'h7FFF, 16'h7FFF, '0, '0);
    send_item(KIND_QUERY, '0, 16'h8000, 16'h8000, '0, '0);
    send_item(KIND_LOAD, 4'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_item(KIND_LOAD, 4'd1, 16'h0040, 16'h0, 16'h8000, 16'h0001);
    send_item(KIND_LOAD, 4'd2, 16'h0, 16'h0, 16'h7FFF, 16'h0);
    send_item(KIND_QUERY, '0, 16'h8000, 16'h7FFF, '0, '0);
    send_item(KIND_QUERY, '0, 16'h0, 16'h0, '0, '0);
    set_count(5'd1);
    send_item(KIND_QUERY, '0, 16'h8000, 16'h7FFF, '0, '0);
    set_count(5'd16);
    for (int i = 0; i < 470; i++) begin
      if (i == 150) set_count(5'd3);
      if (i == 300) set_count(5'($urandom_range(17, 31)));
      if (i == 420) calm = 1'b1;
      if ($urandom_range(0, 2) == 0) rand_load($urandom_range(0, 15));
      else rand_query();
    end
    set_count(5'd0);
    send_item(KIND_QUERY, '0, 16'($urandom), 16'($urandom), '0, '0);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) $display("tb_gaussian_sum_field_eval: done, clean");
    else $display("tb_gaussian_sum_field_eval: done, errors");
    $finish;
  end

  initial begin
    #400000;
    $display("tb_gaussian_sum_field_eval: done, errors");
    $finish;
  end
endmodule

// ===== gaussian_sum_field_eval.f =====
sv/gsfe_pkg.sv
sv/gsfe_ctrl.sv
sv/gsfe_dp.sv
sv/gaussian_sum_field_eval.sv
tb/sv/gsfe_checker.sv
tb/sv/tb_gaussian_sum_field_eval.sv
